// ----- sv/fbprd_pkg.sv -----
package fbprd_pkg;

  // Line width clamp
  localparam int unsigned MAX_LINE = 4096;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Command codes on the input channel
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_START  = 2'd0;
  localparam cmd_t CMD_BYTE   = 2'd1;
  localparam cmd_t CMD_END    = 2'd2;
  localparam cmd_t CMD_IGNORE = 2'd3;

  // Result kinds
  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Classified item handed from front to back
  typedef struct packed {
    cmd_t        op;
    logic [7:0]  code_byte;
    logic [11:0] start_pos;
    logic [12:0] width;
    logic        keep;
  } item_t;

  // One result item
  typedef struct packed {
    logic        kind;
    logic [12:0] position;
    logic [8:0]  run_length;
    logic [3:0]  colour;
    logic        overflow;
    logic        last;
  } result_t;

endpackage

// ----- sv/fbprd_front.sv -----
module fbprd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic [7:0]          in_code_byte,
  input  logic [11:0]         in_start_pos,
  input  logic [12:0]         in_line_width,
  input  logic                in_keep_colour_one,
  output logic                q_valid,
  output fbprd_pkg::item_t    q_item,
  input  logic                q_pop
);

  localparam int unsigned QDEPTH = fbprd_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  fbprd_pkg::item_t  q_mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  fbprd_pkg::item_t  cls_item;
  logic              cls_keep;
  logic              wr_en;
  logic              rd_en;

  // Classify: drop unknown commands, clamp the width
  always_comb begin
    cls_item.op        = in_command;
    cls_item.code_byte = in_code_byte;
    cls_item.start_pos = in_start_pos;
    cls_item.keep      = in_keep_colour_one;
    if (32'(in_line_width) > fbprd_pkg::MAX_LINE) begin
      cls_item.width = 13'(fbprd_pkg::MAX_LINE);
    end else begin
      cls_item.width = in_line_width;
    end
    case (in_command)
      fbprd_pkg::CMD_START,
      fbprd_pkg::CMD_BYTE,
      fbprd_pkg::CMD_END: cls_keep = 1'b1;
      default:            cls_keep = 1'b0;
    endcase
  end

  assign in_stall = (count_r == CNT_W'(QDEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  assign wr_en = in_valid && !in_stall && cls_keep;
  assign rd_en = q_pop && q_valid;

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_mem_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

// ----- sv/fbprd_back.sv -----
module fbprd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  fbprd_pkg::item_t    q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output fbprd_pkg::result_t  out_res
);

  // Engine states
  localparam logic ST_WAIT = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // String phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_DECODE = 2'd1;
  localparam logic [1:0] PH_TRAIL  = 2'd2;

  // Run length offsets of the code families
  localparam logic [8:0] LEN_ZERO_BASE  = 9'd2;
  localparam logic [8:0] LEN_SHORT_BASE = 9'd4;
  localparam logic [8:0] LEN_MID_BASE   = 9'd9;
  localparam logic [8:0] LEN_LONG_BASE  = 9'd25;
  localparam logic [1:0] MAX_RES        = 2'd3;
  localparam logic [5:0] HOLD_MAX       = 6'd24;

  logic                state_r, state_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic [12:0]         pos_r, pos_nxt;
  logic [12:0]         wlim_r, wlim_nxt;
  logic                skip_r, skip_nxt;
  logic [31:0]         win_r, win_nxt;
  logic [5:0]          wlen_r, wlen_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  fbprd_pkg::result_t  pend_r, pend_nxt;
  logic                out_vld_r, out_vld_nxt;
  fbprd_pkg::result_t  out_r, out_nxt;

  logic                slot_free;
  logic                push;
  fbprd_pkg::result_t  push_res;

  // Code decode signals
  logic [31:0]         topw;
  logic [4:0]          need;
  logic [8:0]          len;
  logic [3:0]          col;
  logic                endc;
  logic [12:0]         room;
  logic [8:0]          clip;
  logic [1:0]          eff_phase;
  logic                stop;
  logic                brk;
  logic                emit;
  logic                term;
  fbprd_pkg::result_t  nres;
  logic [1:0]          fin_phase;
  logic [5:0]          fin_len;
  logic [5:0]          rem_len;

  assign slot_free = !out_vld_r || !out_stall;

  // Pixel code decode from the top-aligned window
  always_comb begin
    topw = win_r << (6'd32 - wlen_r);
    need = 5'd4;
    len  = 9'd1;
    col  = topw[31:28];
    endc = 1'b0;
    if (topw[31:28] == 4'd0) begin
      if (!topw[27]) begin
        need = 5'd8;
        col  = 4'd0;
        len  = 9'(topw[26:24]) + LEN_ZERO_BASE;
        endc = (topw[26:24] == 3'd0);
      end else if (!topw[26]) begin
        need = 5'd12;
        len  = 9'(topw[25:24]) + LEN_SHORT_BASE;
        col  = topw[23:20];
      end else begin
        case (topw[25:24])
          2'd0: begin
            need = 5'd8;
            len  = 9'd1;
            col  = 4'd0;
          end
          2'd1: begin
            need = 5'd8;
            len  = 9'd2;
            col  = 4'd0;
          end
          2'd2: begin
            need = 5'd16;
            len  = 9'(topw[23:20]) + LEN_MID_BASE;
            col  = topw[19:16];
          end
          default: begin
            need = 5'd20;
            len  = 9'(topw[23:16]) + LEN_LONG_BASE;
            col  = topw[15:12];
          end
        endcase
      end
    end
    room = wlim_r - pos_r;
    clip = (13'(len) < room) ? len : room[8:0];
  end

  // Engine control
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    wlim_nxt     = wlim_r;
    skip_nxt     = skip_r;
    win_nxt      = win_r;
    wlen_nxt     = wlen_r;
    cnt_nxt      = cnt_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    q_pop        = 1'b0;
    push         = 1'b0;
    push_res     = pend_r;
    nres         = '0;
    emit         = 1'b0;
    term         = 1'b0;
    brk          = 1'b0;
    fin_phase    = phase_r;
    fin_len      = '0;
    rem_len      = 6'(wlen_r - 6'(need));

    eff_phase = (phase_r == PH_DECODE && pos_r >= wlim_r) ? PH_TRAIL : phase_r;
    stop      = (cnt_r == MAX_RES) || (phase_r == PH_IDLE);

    case (state_r)
      ST_WAIT: begin
        if (q_valid) begin
          case (q_item.op)
            fbprd_pkg::CMD_START: begin
              q_pop     = 1'b1;
              wlim_nxt  = q_item.width;
              pos_nxt   = 13'(q_item.start_pos);
              skip_nxt  = q_item.keep;
              win_nxt   = '0;
              wlen_nxt  = '0;
              phase_nxt = (13'(q_item.start_pos) < q_item.width) ? PH_DECODE : PH_TRAIL;
            end
            fbprd_pkg::CMD_END: begin
              if (phase_r == PH_IDLE) begin
                q_pop = 1'b1;
              end else if (slot_free) begin
                q_pop             = 1'b1;
                push              = 1'b1;
                push_res          = '0;
                push_res.kind     = fbprd_pkg::KIND_DONE;
                push_res.position = pos_r;
                push_res.overflow = (phase_r == PH_TRAIL) && (win_r != '0);
                push_res.last     = 1'b1;
                win_nxt           = '0;
                wlen_nxt          = '0;
                phase_nxt         = PH_IDLE;
              end
            end
            fbprd_pkg::CMD_BYTE: begin
              q_pop = 1'b1;
              if (phase_r != PH_IDLE) begin
                win_nxt   = {win_r[23:0], q_item.code_byte};
                wlen_nxt  = wlen_r + 6'd8;
                cnt_nxt   = '0;
                state_nxt = ST_RUN;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end

      default: begin
        // One loop step: classify this step's outcome
        if (!stop) begin
          if (eff_phase == PH_TRAIL) begin
            if (wlen_r < 6'd8) begin
              brk = 1'b1;
            end else begin
              emit          = 1'b1;
              term          = 1'b1;
              nres.kind     = fbprd_pkg::KIND_DONE;
              nres.position = pos_r;
              nres.overflow = (topw[31:24] != 8'd0);
            end
          end else if (6'(need) > wlen_r) begin
            brk = 1'b1;
          end else if (endc) begin
            emit          = 1'b1;
            term          = 1'b1;
            nres.kind     = fbprd_pkg::KIND_DONE;
            nres.position = pos_r;
          end else begin
            emit            = !(skip_r && col == 4'd1);
            nres.kind       = fbprd_pkg::KIND_RUN;
            nres.position   = pos_r;
            nres.run_length = clip;
            nres.colour     = col;
          end
        end

        if (stop || brk) begin
          // Close the byte: flush the held result as the last one
          fin_phase = stop ? phase_r : eff_phase;
          if (fin_phase != PH_IDLE) begin
            fin_len = (wlen_r > HOLD_MAX) ? HOLD_MAX : wlen_r;
          end
          if (!pend_vld_r || slot_free) begin
            push          = pend_vld_r;
            push_res      = pend_r;
            push_res.last = 1'b1;
            pend_vld_nxt  = 1'b0;
            phase_nxt     = fin_phase;
            wlen_nxt      = fin_len;
            win_nxt       = win_r & ~(32'hFFFF_FFFF << fin_len);
            state_nxt     = ST_WAIT;
          end
        end else if (!(emit && pend_vld_r) || slot_free) begin
          // Advance one code; a new result displaces the held one
          if (emit) begin
            push         = pend_vld_r;
            push_res     = pend_r;
            pend_vld_nxt = 1'b1;
            pend_nxt     = nres;
            cnt_nxt      = cnt_r + 1'b1;
          end
          if (term) begin
            phase_nxt = PH_IDLE;
            wlen_nxt  = '0;
            win_nxt   = '0;
          end else begin
            phase_nxt = eff_phase;
            pos_nxt   = pos_r + 13'(clip);
            wlen_nxt  = rem_len;
            win_nxt   = win_r & ~(32'hFFFF_FFFF << rem_len);
          end
        end
      end
    endcase
  end

  // Output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (push) begin
      out_vld_nxt = 1'b1;
      out_nxt     = push_res;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_WAIT;
      phase_r    <= PH_IDLE;
      pos_r      <= '0;
      wlim_r     <= '0;
      skip_r     <= 1'b0;
      win_r      <= '0;
      wlen_r     <= '0;
      cnt_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      wlim_r     <= wlim_nxt;
      skip_r     <= skip_nxt;
      win_r      <= win_nxt;
      wlen_r     <= wlen_nxt;
      cnt_r      <= cnt_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Result payloads
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_r;

endmodule

// ----- sv/four_bit_pixel_run_decoder_core.sv -----
// Four-bit pixel-code string decoder for one subtitle line. A start transfer
// sets position, width (clamped to 4096) and the keep-colour-one flag; code
// bytes then yield pixel runs (kind 0) and a finished result (kind 1) that
// ends the string, with out_last marking the final result of each input
// transfer. Inputs enter a two-entry queue, so a new transfer is taken every
// cycle while the queue has room; unknown commands are dropped at the queue
// and never reach the engine. The decode engine behind it handles a start or
// end item, and a code byte that arrives while no string is open, in its
// wait state. A code byte inside a string is loaded, then taken through the
// shared code decoder one step per pixel code it completes or per end-code
// or trailing-bits step, and then the byte is closed. Results leave through
// a single output register; a stalled output holds the engine only when it
// has a result to hand over.
module four_bit_pixel_run_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_code_byte,
  input  logic [11:0] in_start_pos,
  input  logic [12:0] in_line_width,
  input  logic        in_keep_colour_one,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [12:0] out_position,
  output logic [8:0]  out_run_length,
  output logic [3:0]  out_colour,
  output logic        out_overflow,
  output logic        out_last
);

  logic                q_valid;
  logic                q_pop;
  fbprd_pkg::item_t    q_item;
  fbprd_pkg::result_t  out_res;

  fbprd_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_code_byte       (in_code_byte),
    .in_start_pos       (in_start_pos),
    .in_line_width      (in_line_width),
    .in_keep_colour_one (in_keep_colour_one),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop)
  );

  fbprd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind       = out_res.kind;
  assign out_position   = out_res.position;
  assign out_run_length = out_res.run_length;
  assign out_colour     = out_res.colour;
  assign out_overflow   = out_res.overflow;
  assign out_last       = out_res.last;

endmodule

// ----- sv/fbprd_checker.sv -----
module fbprd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic [12:0] out_position,
  input logic [8:0]  out_run_length,
  input logic [3:0]  out_colour,
  input logic        out_overflow,
  input logic        out_last
);

  // A finished result carries no run and always closes its transfer
  a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == fbprd_pkg::KIND_DONE |->
      out_run_length == 9'd0 && out_colour == 4'd0 && out_last)
    else $error("finished result with run fields or without last");

  // Runs are never empty and never flag overflow
  a_run_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == fbprd_pkg::KIND_RUN |->
      out_run_length != 9'd0 && !out_overflow)
    else $error("run result empty or with overflow");

  // Clipping keeps every run inside the widest line
  a_run_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == fbprd_pkg::KIND_RUN |->
      (32'(out_position) + 32'(out_run_length)) <= fbprd_pkg::MAX_LINE)
    else $error("run extends past the line limit");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_kind) && $stable(out_position) &&
      $stable(out_run_length) && $stable(out_colour) && $stable(out_last))
    else $error("stalled result changed");

  // Nothing leaves in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind four_bit_pixel_run_decoder_core fbprd_checker u_fbprd_checker (.*);

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 300;

  // Predicts pixel runs and finished results, and checks them in order
  class run_scoreboard;
    typedef enum {PH_IDLE, PH_DECODE, PH_TRAIL} phase_t;

    phase_t               ph;
    bit [23:0]            held_bits;
    int                   nheld;
    int                   pos;
    int                   lim;
    bit                   skip_one;
    bit [39:0]            win;
    int                   wlen;
    fbprd_pkg::result_t   fresh[$];
    fbprd_pkg::result_t   pending_runs[$];
    int                   errors;

    function new();
      ph = PH_IDLE;
      held_bits = '0;
      nheld = 0;
      pos = 0;
      lim = 0;
      skip_one = 0;
      errors = 0;
    endfunction

    function bit [39:0] low_mask(int n);
      return (40'd1 << n) - 40'd1;
    endfunction

    // k bits starting off bits into the window, msb first
    function int bits_at(int off, int k);
      return int'((win >> (wlen - off - k)) & low_mask(k));
    endfunction

    function void emit(logic kind, int p, int len, int col, bit ovf);
      fbprd_pkg::result_t r;
      r.kind = kind;
      r.position = p[12:0];
      r.run_length = len[8:0];
      r.colour = col[3:0];
      r.overflow = ovf;
      r.last = 1'b0;
      fresh.insert(fresh.size(), r);
    endfunction

    // Clip at the line width; colour one is skipped when keep is set
    function void add_run(int len, int col);
      int room;
      int clip;
      room = lim - pos;
      clip = (len < room) ? len : room;
      if (!(skip_one && col == 1))
        emit(fbprd_pkg::KIND_RUN, pos, clip, col, 1'b0);
      pos += clip;
    endfunction

    // Work out the results of one accepted input transfer
    function void decode_item(fbprd_pkg::item_t it);
      int need;
      int len;
      int col;
      int sel;
      fresh.delete();
      if (it.op == fbprd_pkg::CMD_START) begin
        lim = (it.width > fbprd_pkg::MAX_LINE) ? int'(fbprd_pkg::MAX_LINE) : int'(it.width);
        pos = int'(it.start_pos);
        skip_one = it.keep;
        held_bits = '0;
        nheld = 0;
        ph = (pos < lim) ? PH_DECODE : PH_TRAIL;
        return;
      end
      if (it.op == fbprd_pkg::CMD_IGNORE || ph == PH_IDLE)
        return;

      if (it.op == fbprd_pkg::CMD_END) begin
        // missing trailing bits count as zero
        emit(fbprd_pkg::KIND_DONE, pos, 0, 0,
             ph == PH_TRAIL && (held_bits & low_mask(nheld)) != 0);
        held_bits = '0;
        nheld = 0;
        ph = PH_IDLE;
      end else begin
        win = (40'(held_bits) << 8) | 40'(it.code_byte);
        wlen = nheld + 8;
        while (fresh.size() < 3 && ph != PH_IDLE) begin
          if (ph == PH_DECODE && pos >= lim)
            ph = PH_TRAIL;
          if (ph == PH_TRAIL) begin
            if (wlen < 8)
              break;
            emit(fbprd_pkg::KIND_DONE, pos, 0, 0, bits_at(0, 8) != 0);
            ph = PH_IDLE;
            wlen = 0;
            break;
          end
          if (wlen < 4)
            break;
          col = bits_at(0, 4);
          if (col != 0) begin
            need = 4;
            len = 1;
          end else begin
            if (wlen < 5)
              break;
            if (bits_at(4, 1) == 0) begin
              if (wlen < 8)
                break;
              len = bits_at(5, 3);
              if (len == 0) begin
                // end-of-string code
                emit(fbprd_pkg::KIND_DONE, pos, 0, 0, 1'b0);
                ph = PH_IDLE;
                wlen = 0;
                break;
              end
              need = 8;
              len += 2;
              col = 0;
            end else begin
              if (wlen < 6)
                break;
              if (bits_at(5, 1) == 0) begin
                if (wlen < 12)
                  break;
                need = 12;
                len = bits_at(6, 2) + 4;
                col = bits_at(8, 4);
              end else begin
                if (wlen < 8)
                  break;
                sel = bits_at(6, 2);
                if (sel == 0) begin
                  need = 8;
                  len = 1;
                  col = 0;
                end else if (sel == 1) begin
                  need = 8;
                  len = 2;
                  col = 0;
                end else if (sel == 2) begin
                  if (wlen < 16)
                    break;
                  need = 16;
                  len = bits_at(8, 4) + 9;
                  col = bits_at(12, 4);
                end else begin
                  if (wlen < 20)
                    break;
                  need = 20;
                  len = bits_at(8, 8) + 25;
                  col = bits_at(16, 4);
                end
              end
            end
          end
          add_run(len, col);
          wlen -= need;
          win &= low_mask(wlen);
        end
        if (ph == PH_IDLE)
          wlen = 0;
        if (wlen > 24)
          wlen = 24;
        nheld = wlen;
        held_bits = 24'(win & low_mask(wlen));
      end

      if (fresh.size() > 0)
        fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i])
        pending_runs.insert(pending_runs.size(), fresh[i]);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check(fbprd_pkg::result_t got);
      fbprd_pkg::result_t want;
      if (pending_runs.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual kind %0d pos %0d",
                 $time, got.kind, got.position);
        return;
      end
      want = pending_runs.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("position", want.position, got.position);
      compare_field("run_length", want.run_length, got.run_length);
      compare_field("colour", want.colour, got.colour);
      compare_field("overflow", want.overflow, got.overflow);
      compare_field("last", want.last, got.last);
    endfunction

    function int pending();
      return pending_runs.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [7:0]  in_code_byte;
  logic [11:0] in_start_pos;
  logic [12:0] in_line_width;
  logic        in_keep_colour_one;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic [12:0] out_position;
  logic [8:0]  out_run_length;
  logic [3:0]  out_colour;
  logic        out_overflow;
  logic        out_last;

  run_scoreboard sb = new();
  bit            code_bits[$];
  bit            calm = 1'b0;
  int            useful = 0;
  int            results_seen = 0;
  int            quiet = 0;

  four_bit_pixel_run_decoder_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_code_byte       (in_code_byte),
    .in_start_pos       (in_start_pos),
    .in_line_width      (in_line_width),
    .in_keep_colour_one (in_keep_colour_one),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_position       (out_position),
    .out_run_length     (out_run_length),
    .out_colour         (out_colour),
    .out_overflow       (out_overflow),
    .out_last           (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one item from a falling edge until it is taken
  task automatic send(fbprd_pkg::item_t it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= it.op;
    in_code_byte <= it.code_byte;
    in_start_pos <= it.start_pos;
    in_line_width <= it.width;
    in_keep_colour_one <= it.keep;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.decode_item(it);
    @(negedge clk);
  endtask

  task automatic send_start(int sp, int w, bit k);
    fbprd_pkg::item_t it;
    it.op = fbprd_pkg::CMD_START;
    it.code_byte = 8'($urandom_range(0, 255));
    it.start_pos = sp[11:0];
    it.width = w[12:0];
    it.keep = k;
    send(it);
  endtask

  // Fields unused by the command are random
  task automatic send_op(fbprd_pkg::cmd_t c, bit [7:0] b);
    fbprd_pkg::item_t it;
    it.op = c;
    it.code_byte = b;
    it.start_pos = 12'($urandom_range(0, 4095));
    it.width = 13'($urandom_range(0, 8191));
    it.keep = 1'($urandom_range(0, 1));
    send(it);
  endtask

  function automatic void put_code(int v, int n);
    for (int i = n - 1; i >= 0; i--)
      code_bits.insert(code_bits.size(), v[i]);
  endfunction

  function automatic int pick_colour();
    return ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(0, 15);
  endfunction

  function automatic void add_random_code();
    case ($urandom_range(0, 6))
      0: put_code(($urandom_range(0, 2) == 0) ? 1 : $urandom_range(1, 15), 4);
      1: begin
        put_code(0, 5);
        put_code($urandom_range(1, 7), 3);
      end
      2: begin
        put_code(2, 6);
        put_code($urandom_range(0, 3), 2);
        put_code(pick_colour(), 4);
      end
      3: put_code(8'h0C, 8);
      4: put_code(8'h0D, 8);
      5: begin
        put_code(8'h0E, 8);
        put_code($urandom_range(0, 15), 4);
        put_code(pick_colour(), 4);
      end
      default: begin
        put_code(8'h0F, 8);
        put_code($urandom_range(0, 255), 8);
        put_code(pick_colour(), 4);
      end
    endcase
  endfunction

  task automatic noise();
    case ($urandom_range(0, 2))
      0: send_op(fbprd_pkg::CMD_IGNORE, 8'($urandom_range(0, 255)));
      1: send_op(fbprd_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
      default: send_op(fbprd_pkg::CMD_END, 8'($urandom_range(0, 255)));
    endcase
  endtask

  // One line: start, a well-formed code string, sometimes cut or broken
  task automatic random_line();
    int        w;
    int        lim;
    int        sp;
    int        nbytes;
    int        cut;
    bit [7:0]  b;
    code_bits.delete();
    repeat ($urandom_range(1, 12)) add_random_code();
    if ($urandom_range(0, 9) < 7)
      put_code(0, 8);
    put_code($urandom_range(0, 1) ? $urandom_range(0, 255) : 0, 8);
    while (code_bits.size() % 8 != 0)
      put_code($urandom_range(0, 1), 1);

    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: w = $urandom_range(1, 300);
      6: w = $urandom_range(0, 8191);
      7: w = $urandom_range(4096, 8191);
      8: w = 0;
      default: w = $urandom_range(1, 40);
    endcase
    lim = (w > int'(fbprd_pkg::MAX_LINE)) ? int'(fbprd_pkg::MAX_LINE) : w;
    if (lim > 0 && $urandom_range(0, 4) != 0)
      sp = lim - 1 - int'($urandom_range(0, (lim - 1 < 250) ? lim - 1 : 250));
    else
      sp = $urandom_range(0, 4095);
    send_start(sp, w, 1'($urandom_range(0, 1)));
    useful++;

    nbytes = code_bits.size() / 8;
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, nbytes) : nbytes;
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 19) == 0)
        noise();
      for (int j = 0; j < 8; j++)
        b[7 - j] = code_bits[8 * i + j];
      send_op(fbprd_pkg::CMD_BYTE, b);
      useful++;
    end
    if ($urandom_range(0, 2) == 0) begin
      send_op(fbprd_pkg::CMD_END, 8'($urandom_range(0, 255)));
      useful++;
    end
    if ($urandom_range(0, 7) == 0)
      noise();
  endtask

  // Result side: short stall bursts, and one long hold-off to fill the block
  initial begin
    bit long_done;
    long_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (!long_done && results_seen >= 40) begin
        long_done = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check('{kind: out_kind, position: out_position, run_length: out_run_length,
                 colour: out_colour, overflow: out_overflow, last: out_last});
      results_seen++;
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    bit [7:0] seq_a [12];
    bit [7:0] seq_b [5];
    seq_a = '{8'h12, 8'h05, 8'h0C, 8'h0D, 8'h0B, 8'h7F,
              8'h0E, 8'hA5, 8'h0F, 8'hFF, 8'h30, 8'h80};
    seq_b = '{8'h11, 8'h0F, 8'h00, 8'h10, 8'h00};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= fbprd_pkg::CMD_IGNORE;
    in_code_byte <= '0;
    in_start_pos <= '0;
    in_line_width <= '0;
    in_keep_colour_one <= 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // idle block ignores bytes, unknown commands and exhausted data
    send_op(fbprd_pkg::CMD_BYTE, 8'hFF);
    send_op(fbprd_pkg::CMD_IGNORE, 8'h00);
    send_op(fbprd_pkg::CMD_END, 8'h00);

    // every code form, a long run clipped at the width, overflow set
    send_start(0, 100, 1'b0);
    foreach (seq_a[i])
      send_op(fbprd_pkg::CMD_BYTE, seq_a[i]);

    // colour one skipped, then the end code
    send_start(10, 4096, 1'b1);
    foreach (seq_b[i])
      send_op(fbprd_pkg::CMD_BYTE, seq_b[i]);

    // clamped width at the last pixel, exhausted with held bits
    send_start(4095, 8191, 1'b0);
    send_op(fbprd_pkg::CMD_BYTE, 8'hFF);
    send_op(fbprd_pkg::CMD_END, 8'h00);

    // zero width goes straight to the trailing bits
    send_start(5, 0, 1'b0);
    send_op(fbprd_pkg::CMD_BYTE, 8'h00);

    // partial code abandoned by a new start, then exhausted while decoding
    send_start(0, 50, 1'b0);
    send_op(fbprd_pkg::CMD_BYTE, 8'h0E);
    send_op(fbprd_pkg::CMD_IGNORE, 8'h5A);
    send_start(3, 20, 1'b0);
    send_op(fbprd_pkg::CMD_BYTE, 8'h0F);
    send_op(fbprd_pkg::CMD_END, 8'h00);

    // random lines; no idling near the end
    while (useful < RANDOM_ITEMS) begin
      if (useful > RANDOM_ITEMS * 85 / 100)
        calm = 1'b1;
      random_line();
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
